// File: hdl/q4bd_pkg.sv
package q4bd_pkg;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ELEMENTS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLUSH_SUBNORMAL = 1'd1;
	localparam int CFG_DATA_W = 9;

	localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
	localparam logic [31:0] INF_BITS    = 32'h7F80_0000;
	localparam logic [3:0]  WEIGHT_BIAS = 4'd8;

	typedef struct packed {
		logic [7:0]  packed_byte;
		logic [15:0] block_scale;
		logic        final_byte;
		logic        high_present;
	} in_item_t;

	typedef struct packed {
		logic [31:0] even_value;
		logic [31:0] odd_value;
		logic        odd_valid;
		logic        tensor_end;
	} out_item_t;

	// Half to single conversion; subnormals normalised or flushed.
	function automatic logic [31:0] half_to_single(input logic [15:0] h, input logic flush);
		logic [4:0] ex;
		logic [9:0] man;
		logic [3:0] p;
		logic [22:0] frac;
		logic [7:0] sexp;
		begin
			ex = h[14:10];
			man = h[9:0];
			p = 4'd0;
			for (int i = 0; i < 10; i++) begin
				if (man[i]) begin
					p = 4'(i);
				end
			end
			frac = 23'({man, 13'd0} << (4'd10 - p));
			sexp = 8'(p) + 8'd103;
			if (ex == 5'd0) begin
				if (man == 10'd0 || flush) begin
					half_to_single = {h[15], 31'd0};
				end else begin
					half_to_single = {h[15], sexp, frac};
				end
			end else if (ex == 5'h1F) begin
				half_to_single = {h[15], 8'hFF, man, 13'd0};
			end else begin
				half_to_single = {h[15], 8'(ex) + 8'd112, man, 13'd0};
			end
		end
	endfunction

	// Exact product of a single scale (low 13 fraction bits clear) and weight nibble-8.
	function automatic logic [31:0] scale_weight(input logic [31:0] s, input logic [3:0] nib);
		logic       wneg;
		logic [3:0] mag;
		logic       sign;
		logic [7:0] ex;
		logic [26:0] m;
		begin
			wneg = (nib < WEIGHT_BIAS);
			mag = wneg ? (WEIGHT_BIAS - nib) : (nib - WEIGHT_BIAS);
			sign = s[31] ^ wneg;
			ex = s[30:23];
			m = 27'({1'b1, s[22:0]}) * 27'(mag);
			if (ex == 8'hFF) begin
				if (s[22:0] != 23'd0) begin
					scale_weight = s | QUIET_BIT;
				end else if (mag == 4'd0) begin
					scale_weight = DEFAULT_NAN;
				end else begin
					scale_weight = {sign, 31'd0} | INF_BITS;
				end
			end else if (ex == 8'd0 || mag == 4'd0) begin
				scale_weight = {sign, 31'd0};
			end else if (m[26]) begin
				scale_weight = {sign, ex + 8'd3, m[25:3]};
			end else if (m[25]) begin
				scale_weight = {sign, ex + 8'd2, m[24:2]};
			end else if (m[24]) begin
				scale_weight = {sign, ex + 8'd1, m[23:1]};
			end else begin
				scale_weight = {sign, ex, m[22:0]};
			end
		end
	endfunction

endpackage

// File: hdl/q4bd_if.sv
interface q4bd_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/q4bd_front.sv
// Input register stage: block counting, scale capture and half to single conversion.
module q4bd_front
	import q4bd_pkg::*;
#(
	parameter int MAX_BLOCK = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  in_item_t    item,
	input  logic [8:0]  block_elements,
	input  logic        flush_subnormal,
	output logic [31:0] scale_s1,
	output logic [7:0]  byte_s1,
	output logic        fin_s1,
	output logic        hi_s1
);
	localparam logic [8:0] MAXB = (MAX_BLOCK > 256) ? 9'd256 : 9'(MAX_BLOCK);

	logic [6:0]  byte_in_block_q;
	logic [15:0] held_scale_q;
	logic [8:0]  elems;
	logic [7:0]  bytes;
	logic [15:0] cur_scale;
	logic [7:0]  next_cnt;

	always_comb begin
		elems = (block_elements > MAXB) ? MAXB : block_elements;
		bytes = elems[8:1];
		if (bytes == 8'd0) begin
			bytes = 8'd1;
		end
		cur_scale = (byte_in_block_q == 7'd0) ? item.block_scale : held_scale_q;
		next_cnt = 8'(byte_in_block_q) + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_block_q <= '0;
			held_scale_q <= '0;
		end else if (take) begin
			held_scale_q <= cur_scale;
			if (item.final_byte || next_cnt >= bytes) begin
				byte_in_block_q <= '0;
			end else begin
				byte_in_block_q <= next_cnt[6:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			scale_s1 <= half_to_single(cur_scale, flush_subnormal);
			byte_s1 <= item.packed_byte;
			fin_s1 <= item.final_byte;
			hi_s1 <= item.high_present;
		end
	end
endmodule

// File: hdl/q4bd_mult.sv
// Result stage logic: both nibble products.
module q4bd_mult
	import q4bd_pkg::*;
(
	input  logic [31:0] scale,
	input  logic [7:0]  pbyte,
	input  logic        fin,
	input  logic        hi,
	output out_item_t   res
);
	always_comb begin
		res.even_value = scale_weight(scale, pbyte[3:0]);
		res.odd_value = hi ? scale_weight(scale, pbyte[7:4]) : 32'd0;
		res.odd_valid = hi;
		res.tensor_end = fin;
	end
endmodule

// File: hdl/q4_block_dequantizer.sv
// Q4 block dequantiser.
// Input channel in_ch carries one packed byte of two 4-bit weights per item,
// with a half-precision block scale that is sampled only on the first byte of
// each block, a final-byte flag and a high-nibble-present flag.
// Output channel out_ch returns one item per input: both weights, centred by
// subtracting eight and multiplied by the scale, as single-precision bits.
// The configuration port writes block_elements (index 0) and flush_subnormal
// (index 1); write only while the block is idle.
// There are two register stages: the first tracks the block position and
// converts the scale, the second forms the exact products. Throughput is one
// item per cycle, set by the two register stages which both advance whenever
// the output stage is empty or being emptied.
// When the receiver stalls, the output register holds its item and the input
// register stalls behind it, so at most two items are held inside.
// Reset clears the block count, the held scale and the valid flags, and sets
// block_elements to 32 and flush_subnormal to 0.
module q4_block_dequantizer
	import q4bd_pkg::*;
#(
	parameter int MAX_BLOCK = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	q4bd_if.sink                  in_ch,
	q4bd_if.source                out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	logic [8:0]  block_elements_q;
	logic        flush_subnormal_q;
	logic        v_s1;
	logic        v_s2;
	logic        adv_s2;
	logic        adv_s1;
	logic [31:0] scale_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;
	logic        hi_s1;
	out_item_t   res;
	out_item_t   res_s2;

	// A stage advances when the stage after it is empty or handing on.
	assign adv_s2 = !v_s2 || out_ch.ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_elements_q <= 9'd32;
			flush_subnormal_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BLOCK_ELEMENTS: block_elements_q <= cfg_wdata;
				REG_FLUSH_SUBNORMAL: flush_subnormal_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_ch.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	q4bd_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(in_ch.valid && adv_s1),
		.item(in_ch.data),
		.block_elements(block_elements_q),
		.flush_subnormal(flush_subnormal_q),
		.scale_s1(scale_s1),
		.byte_s1(byte_s1),
		.fin_s1(fin_s1),
		.hi_s1(hi_s1)
	);

	q4bd_mult u_mult (
		.scale(scale_s1),
		.pbyte(byte_s1),
		.fin(fin_s1),
		.hi(hi_s1),
		.res(res)
	);

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid = v_s2;
	assign out_ch.data = res_s2;
endmodule
